### hw/rtl/lrs_pkg.sv
// ----------------------------------------------------------------------------
// LED linear resampler package
// Sizes, opcodes, the per-LED position tables and the reciprocal constants
// shared by the resampler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lrs_pkg;

  localparam int LOGICAL_PIXELS = 32;
  localparam int PHYSICAL_LEDS  = 16;

  localparam int CHAN_W   = 8;
  localparam int CHANNELS = 4;
  localparam int COLOR_W  = CHAN_W * CHANNELS;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

  localparam int OPCODE_W    = 2;
  localparam int IN_INDEX_W  = 5;
  localparam int OUT_INDEX_W = 6;

  localparam int PIX_SPAN = LOGICAL_PIXELS - 1;
  localparam int LED_SPAN = PHYSICAL_LEDS - 1;

  localparam int PIX_W = $clog2(LOGICAL_PIXELS);
  localparam int LED_W = $clog2(PHYSICAL_LEDS);
  localparam int WGT_W = $clog2(PHYSICAL_LEDS);

  // Width of one weighted channel sum, and the reciprocal used to floor it
  // by the LED span without a divider.
  localparam int SUM_W = CHAN_W + WGT_W + 1;
  localparam int RCP_K = 24;
  localparam int RCP_W = RCP_K + 1;
  localparam int RCP_M = ((2 ** RCP_K) + LED_SPAN - 1) / LED_SPAN;
  localparam int QUO_W = SUM_W + 1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET    = 2'd0,
    OP_FILL   = 2'd1,
    OP_RENDER = 2'd2
  } op_t;

  typedef logic [PIX_W-1:0] pix_tab_t [PHYSICAL_LEDS];
  typedef logic [WGT_W-1:0] wgt_tab_t [PHYSICAL_LEDS];

  typedef struct packed {
    logic              vld;
    logic [CHAN_W-1:0] ca;
    logic [CHAN_W-1:0] cb;
    logic [WGT_W-1:0]  wa;
    logic [WGT_W-1:0]  wb;
  } blend_req_t;

  typedef struct packed {
    logic              vld;
    logic [CHAN_W-1:0] chan;
  } blend_rsp_t;

  function automatic pix_tab_t calc_p0_tab();
    pix_tab_t t;
    for (int n = 0; n < PHYSICAL_LEDS; n++) begin
      t[n] = PIX_W'((n * PIX_SPAN) / LED_SPAN);
    end
    return t;
  endfunction

  // The second neighbor is clamped to the last pixel; the final LED then has
  // a zero weight on it and copies the last pixel exactly.
  function automatic pix_tab_t calc_p1_tab();
    pix_tab_t t;
    int       p;
    for (int n = 0; n < PHYSICAL_LEDS; n++) begin
      p = (n * PIX_SPAN) / LED_SPAN + 1;
      if (p > LOGICAL_PIXELS - 1) begin
        p = LOGICAL_PIXELS - 1;
      end
      t[n] = PIX_W'(p);
    end
    return t;
  endfunction

  function automatic wgt_tab_t calc_wb_tab();
    wgt_tab_t t;
    for (int n = 0; n < PHYSICAL_LEDS; n++) begin
      t[n] = WGT_W'((n * PIX_SPAN) % LED_SPAN);
    end
    return t;
  endfunction

  function automatic wgt_tab_t calc_wa_tab();
    wgt_tab_t t;
    for (int n = 0; n < PHYSICAL_LEDS; n++) begin
      t[n] = WGT_W'(LED_SPAN - ((n * PIX_SPAN) % LED_SPAN));
    end
    return t;
  endfunction

  localparam pix_tab_t P0_TAB = calc_p0_tab();
  localparam pix_tab_t P1_TAB = calc_p1_tab();
  localparam wgt_tab_t WA_TAB = calc_wa_tab();
  localparam wgt_tab_t WB_TAB = calc_wb_tab();

endpackage

`default_nettype wire

### hw/rtl/lrs_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/lrs_blend_unit.sv
// ----------------------------------------------------------------------------
// LED resampler channel blend unit
// Two-stage shared unit: weighted sum of two channels, then a floor by the
// LED span through a reciprocal multiply, limited to the channel maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_blend_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lrs_pkg::blend_req_t req,
  output lrs_pkg::blend_rsp_t      rsp
);

  import lrs_pkg::*;

  logic             sum_vld_r;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic             rsp_vld_r;
  logic [CHAN_W-1:0] chan_r;
  logic [CHAN_W-1:0] chan_nxt;
  logic [SUM_W+RCP_W-1:0] prod;
  logic [QUO_W-1:0]       quo;

  assign sum_nxt = SUM_W'(req.ca) * SUM_W'(req.wa) + SUM_W'(req.cb) * SUM_W'(req.wb);

  assign prod = (SUM_W+RCP_W)'(sum_r) * (SUM_W+RCP_W)'(RCP_M);
  assign quo  = prod[RCP_K +: QUO_W];

  always_comb begin
    if (quo > QUO_W'(CHAN_MAX)) begin
      chan_nxt = CHAN_MAX;
    end else begin
      chan_nxt = quo[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
      rsp_vld_r <= 1'b0;
    end else begin
      sum_vld_r <= req.vld;
      rsp_vld_r <= sum_vld_r;
    end
    sum_r  <= sum_nxt;
    chan_r <= chan_nxt;
  end

  assign rsp.vld  = rsp_vld_r;
  assign rsp.chan = chan_r;

endmodule

`default_nettype wire

### hw/rtl/led_linear_resampler_core.sv
// ----------------------------------------------------------------------------
// LED linear resampler core
// Holds the logical pixel colors and renders them onto the physical LEDs by
// linear interpolation, one LED result beat at a time.
//
//   Port group   Direction  Contents
//   in_*         input      opcode, pixel_index, color
//   out_*        output     led_index, led_color, last_of_frame
//
// A set or a fill beat completes in the cycle it is accepted.
// A render works through the LEDs one at a time: two pixel reads through the single RAM
// read port, four channel passes through the shared blend unit and its two
// pipeline stages, then one output state that holds its LED result while
// out_valid is high and out_ready is low.
// The input side is not ready during a render. Reset leaves all pixels zero.
// ----------------------------------------------------------------------------
`default_nettype none

module led_linear_resampler_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [lrs_pkg::OPCODE_W-1:0]   in_opcode,
  input  wire logic [lrs_pkg::IN_INDEX_W-1:0] in_pixel_index,
  input  wire logic [lrs_pkg::COLOR_W-1:0]    in_color,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [lrs_pkg::OUT_INDEX_W-1:0]     out_led_index,
  output logic [lrs_pkg::COLOR_W-1:0]         out_led_color,
  output logic                                out_last_of_frame
);

  import lrs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_CAP_B,
    ST_CALC,
    ST_OUT
  } state_t;

  state_t state_r;
  logic [LED_W-1:0]   led_r;
  logic [2:0]         cnt_r;
  logic [COLOR_W-1:0] pix_a_r;
  logic [COLOR_W-1:0] pix_b_r;
  logic [COLOR_W-1:0] color_r;

  logic [LOGICAL_PIXELS-1:0] valid_r;
  logic [COLOR_W-1:0]        base_r;
  logic                      vld_rd_r;

  logic                    in_fire;
  logic [PIX_W+IN_INDEX_W-1:0] idx_wide;
  logic                    idx_ok;
  logic                    ram_we;
  logic [PIX_W-1:0]        ram_waddr;
  logic [PIX_W-1:0]        ram_raddr;
  logic [COLOR_W-1:0]      ram_rdata;
  logic [COLOR_W-1:0]      pix_rd;
  logic                    is_last;
  logic [1:0]              ch;

  blend_req_t req;
  blend_rsp_t rsp;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign idx_wide  = {{PIX_W{1'b0}}, in_pixel_index};
  assign idx_ok    = idx_wide < (PIX_W+IN_INDEX_W)'(LOGICAL_PIXELS);
  assign ram_waddr = idx_wide[PIX_W-1:0];
  assign ram_we    = in_fire && (in_opcode == OP_SET) && idx_ok;

  assign ram_raddr = (state_r == ST_RD_A) ? P0_TAB[led_r] : P1_TAB[led_r];
  assign pix_rd    = vld_rd_r ? ram_rdata : base_r;

  lrs_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (LOGICAL_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_color),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A fill moves the color into the base register and drops every written
  // entry, so unwritten entries read as the base color.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      base_r  <= '0;
    end else if (in_fire && (in_opcode == OP_FILL)) begin
      valid_r <= '0;
      base_r  <= in_color;
    end else if (ram_we) begin
      valid_r[ram_waddr] <= 1'b1;
    end
    vld_rd_r <= valid_r[ram_raddr];
  end

  assign ch        = cnt_r[1:0];
  assign req.vld   = (state_r == ST_CALC) && !cnt_r[2];
  assign req.ca    = pix_a_r[{ch, 3'b000} +: CHAN_W];
  assign req.cb    = pix_b_r[{ch, 3'b000} +: CHAN_W];
  assign req.wa    = WA_TAB[led_r];
  assign req.wb    = WB_TAB[led_r];

  lrs_blend_unit u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign is_last = (led_r == LED_W'(PHYSICAL_LEDS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      led_r   <= '0;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          led_r <= '0;
          if (in_fire && (in_opcode == OP_RENDER)) begin
            state_r <= ST_RD_A;
          end
        end
        ST_RD_A: begin
          state_r <= ST_RD_B;
        end
        ST_RD_B: begin
          state_r <= ST_CAP_B;
        end
        ST_CAP_B: begin
          cnt_r   <= '0;
          state_r <= ST_CALC;
        end
        ST_CALC: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd5) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            if (is_last) begin
              state_r <= ST_IDLE;
            end else begin
              led_r   <= led_r + LED_W'(1);
              state_r <= ST_RD_A;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
    if (state_r == ST_RD_B) begin
      pix_a_r <= pix_rd;
    end
    if (state_r == ST_CAP_B) begin
      pix_b_r <= pix_rd;
    end
    if (rsp.vld) begin
      color_r <= {rsp.chan, color_r[COLOR_W-1:CHAN_W]};
    end
  end

  assign out_valid         = (state_r == ST_OUT);
  assign out_led_index     = OUT_INDEX_W'(led_r);
  assign out_led_color     = color_r;
  assign out_last_of_frame = is_last;

endmodule

`default_nettype wire
